// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by eapol_supplicant_controller.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define EAPSC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

`define EAPSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define EAPSC_ASSERT(lbl, clk, rstn, prop)

`define EAPSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/eapsc_pkg.sv =====
// ---------------------------------------------------------------------------
// eapsc_pkg
// Types, codes and the back-off table of the EAPOL supplicant controller.
// ---------------------------------------------------------------------------
`default_nettype none

package eapsc_pkg;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_START   = 2'd1,
        OP_LOGOFF  = 2'd2,
        OP_TX_FAIL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        SEND_NONE      = 3'd0,
        SEND_START     = 3'd1,
        SEND_LOGOFF    = 3'd2,
        SEND_IDENTITY  = 3'd3,
        SEND_MD5       = 3'd4,
        SEND_KEEPALIVE = 3'd5
    } frame_t;

    typedef enum logic [2:0] {
        STAT_IDLE       = 3'd0,
        STAT_STARTED    = 3'd1,
        STAT_LOGGED_OFF = 3'd2,
        STAT_SUCCESS    = 3'd3,
        STAT_FAILURE    = 3'd4,
        STAT_NOTIFY     = 3'd5,
        STAT_ERROR      = 3'd6
    } status_t;

    localparam logic [7:0] EAP_CODE_VENDOR  = 8'd0;
    localparam logic [7:0] EAP_CODE_REQUEST = 8'd1;
    localparam logic [7:0] EAP_CODE_SUCCESS = 8'd3;
    localparam logic [7:0] EAP_CODE_FAILURE = 8'd4;

    localparam logic [7:0] EAP_TYPE_IDENTITY = 8'h01;
    localparam logic [7:0] EAP_TYPE_NOTIFY   = 8'h02;
    localparam logic [7:0] EAP_TYPE_MD5      = 8'h04;
    localparam logic [7:0] EAP_TYPE_VENDOR   = 8'h1c;

    localparam logic [7:0]  KEY_TYPE_RESET = 8'd3;
    localparam int unsigned QUIET_WINDOW   = 1800;
    localparam logic [3:0]  TOP_LEVEL      = 4'd8;

    typedef struct packed {
        logic [1:0] op;
        logic [31:0] now_seconds;
        logic [7:0] eapol_packet_type;
        logic [7:0] eap_code;
        logic [7:0] eap_ident;
        logic [7:0] eap_method;
    } item_t;

    typedef struct packed {
        logic [2:0]  send_frame;
        logic [2:0]  session_status;
        logic        running;
        logic [10:0] retry_delay;
        logic        retry_armed;
        logic [31:0] retry_at;
    } result_t;

    typedef struct packed {
        logic [3:0]  level;
        logic [10:0] delay;
    } backoff_t;

    function automatic logic [10:0] delay_for(input logic [3:0] level);
        logic [10:0] d;
        case (level)
            4'd0:    d = 11'd0;
            4'd1:    d = 11'd5;
            4'd2:    d = 11'd15;
            4'd3:    d = 11'd30;
            4'd4:    d = 11'd65;
            4'd5:    d = 11'd300;
            4'd6:    d = 11'd600;
            4'd7:    d = 11'd900;
            4'd8:    d = 11'd1200;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/eapsc_backoff.sv =====
// ---------------------------------------------------------------------------
// eapsc_backoff
// Picks the retry delay and the next back-off level from the current level
// and the time since the last failure.
// ---------------------------------------------------------------------------
`default_nettype none

module eapsc_backoff #(
    parameter int TIME_BITS = 32
) (
    input  wire logic [TIME_BITS-1:0] now_t,
    input  wire logic [TIME_BITS-1:0] last_fail,
    input  wire logic [3:0]           level,
    output eapsc_pkg::backoff_t       bo
);

    logic [TIME_BITS-1:0] elapsed;
    logic [3:0]           lvl;

    assign elapsed = now_t - last_fail;

    always_comb
    begin
        lvl = level;
        if ((elapsed > TIME_BITS'(eapsc_pkg::QUIET_WINDOW)) || (level > eapsc_pkg::TOP_LEVEL))
        begin
            lvl = 4'd0;
        end
        bo.delay = eapsc_pkg::delay_for(lvl);
        bo.level = (lvl < eapsc_pkg::TOP_LEVEL) ? lvl + 4'd1 : lvl;
    end

endmodule

`default_nettype wire

// ===== design/eapsc_ctrl.sv =====
// ---------------------------------------------------------------------------
// eapsc_ctrl
// Session state and the per-request decision: reply frame, status, run flag
// and retry scheduling.
// ---------------------------------------------------------------------------
`default_nettype none

module eapsc_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             update,
    input  wire eapsc_pkg::item_t item,
    input  wire logic [7:0]       key_type,
    output eapsc_pkg::result_t    res
);

    logic                 run_reg, run_next;
    logic [2:0]           status_reg, status_next;
    logic [3:0]           level_reg, level_next;
    logic [TIME_BITS-1:0] last_fail_reg, last_fail_next;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] at_t;
    logic [63:0]          at_wide;
    logic                 take_backoff;
    eapsc_pkg::backoff_t  bo;

    assign now_wide = {32'd0, item.now_seconds};
    assign now_t    = now_wide[TIME_BITS-1:0];
    assign at_t     = now_t + TIME_BITS'(bo.delay);
    assign at_wide  = 64'(at_t);

    eapsc_backoff #(
        .TIME_BITS (TIME_BITS)
    ) u_backoff (
        .now_t     (now_t),
        .last_fail (last_fail_reg),
        .level     (level_reg),
        .bo        (bo)
    );

    always_comb
    begin
        run_next       = run_reg;
        status_next    = status_reg;
        level_next     = level_reg;
        last_fail_next = last_fail_reg;
        take_backoff   = 1'b0;
        res.send_frame  = eapsc_pkg::SEND_NONE;
        res.retry_delay = 11'd0;
        res.retry_armed = 1'b0;
        res.retry_at    = 32'd0;

        case (item.op)
            eapsc_pkg::OP_FRAME:
            begin
                if (run_reg)
                begin
                    if (item.eapol_packet_type == key_type)
                    begin
                        res.send_frame = eapsc_pkg::SEND_KEEPALIVE;
                    end
                    else
                    begin
                        case (item.eap_code)
                            eapsc_pkg::EAP_CODE_VENDOR:
                            begin
                                if (item.eap_method == eapsc_pkg::EAP_TYPE_VENDOR &&
                                    item.eap_ident == 8'd0)
                                begin
                                    status_next = eapsc_pkg::STAT_NOTIFY;
                                end
                            end
                            eapsc_pkg::EAP_CODE_REQUEST:
                            begin
                                if (item.eap_method == eapsc_pkg::EAP_TYPE_IDENTITY)
                                begin
                                    res.send_frame = eapsc_pkg::SEND_IDENTITY;
                                end
                                else if (item.eap_method == eapsc_pkg::EAP_TYPE_NOTIFY)
                                begin
                                    status_next = eapsc_pkg::STAT_NOTIFY;
                                end
                                else if (item.eap_method == eapsc_pkg::EAP_TYPE_MD5)
                                begin
                                    res.send_frame = eapsc_pkg::SEND_MD5;
                                end
                            end
                            eapsc_pkg::EAP_CODE_SUCCESS:
                            begin
                                status_next = eapsc_pkg::STAT_SUCCESS;
                            end
                            eapsc_pkg::EAP_CODE_FAILURE:
                            begin
                                status_next  = eapsc_pkg::STAT_FAILURE;
                                run_next     = 1'b0;
                                take_backoff = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            eapsc_pkg::OP_START:
            begin
                run_next       = 1'b1;
                status_next    = eapsc_pkg::STAT_STARTED;
                res.send_frame = eapsc_pkg::SEND_START;
            end
            eapsc_pkg::OP_LOGOFF:
            begin
                if (run_reg)
                begin
                    res.send_frame = eapsc_pkg::SEND_LOGOFF;
                    status_next    = eapsc_pkg::STAT_LOGGED_OFF;
                end
                run_next = 1'b0;
            end
            default:
            begin
                status_next  = eapsc_pkg::STAT_ERROR;
                take_backoff = 1'b1;
            end
        endcase

        if (take_backoff)
        begin
            level_next     = bo.level;
            last_fail_next = now_t;
            if (bo.delay == 11'd0)
            begin
                run_next       = 1'b1;
                status_next    = eapsc_pkg::STAT_STARTED;
                res.send_frame = eapsc_pkg::SEND_START;
            end
            else
            begin
                run_next        = 1'b0;
                res.retry_delay = bo.delay;
                res.retry_armed = 1'b1;
                res.retry_at    = at_wide[31:0];
            end
        end

        res.session_status = status_next;
        res.running        = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            status_reg    <= eapsc_pkg::STAT_IDLE;
            level_reg     <= 4'd0;
            last_fail_reg <= '0;
        end
        else if (update)
        begin
            run_reg       <= run_next;
            status_reg    <= status_next;
            level_reg     <= level_next;
            last_fail_reg <= last_fail_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/eapol_supplicant_controller.sv =====
// ---------------------------------------------------------------------------
// eapol_supplicant_controller
// 802.1X supplicant controller: reply selection, session status, run flag
// and graded retry back-off.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per frame header
//   or command: op, now_seconds and the EAPOL/EAP header bytes.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   request, in order: send_frame, session_status, running, retry_delay,
//   retry_armed, retry_at.
//   cfg_we / cfg_wdata write the keep-alive EAPOL packet type (reset 3).
//   Write it only while no request is in flight.
//   A request passes from the input register through the decision logic
//   into the result register; a receiver stall holds it in the input register.
//   Throughput: one request per cycle unless the receiver stalls; the session
//   state is updated in the single cycle a request moves from input to result register.
//   Reset clears the run flag, status (idle), back-off level and last
//   failure time, and empties both registers.
//   When the receiver stalls, the result holds, the input register holds its
//   request and in_stall rises once the input register is full.
// ---------------------------------------------------------------------------
`default_nettype none

module eapol_supplicant_controller #(
    parameter int TIME_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] now_seconds,
    input  wire logic [7:0]  eapol_packet_type,
    input  wire logic [7:0]  eap_code,
    input  wire logic [7:0]  eap_ident,
    input  wire logic [7:0]  eap_method,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       send_frame,
    output logic [2:0]       session_status,
    output logic             running,
    output logic [10:0]      retry_delay,
    output logic             retry_armed,
    output logic [31:0]      retry_at
);

    logic [7:0]          key_type_reg;
    logic                in_vld_reg, in_vld_next;
    eapsc_pkg::item_t    item_reg;
    logic                out_vld_reg, out_vld_next;
    eapsc_pkg::result_t  result_reg;
    eapsc_pkg::result_t  result_next;
    logic                advance;
    logic                move;
    logic                accept;

    assign advance  = !out_vld_reg || !out_stall;
    assign move     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (move)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    eapsc_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (move),
        .item     (item_reg),
        .key_type (key_type_reg),
        .res      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_type_reg <= eapsc_pkg::KEY_TYPE_RESET;
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_type_reg <= cfg_wdata;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op                <= op;
            item_reg.now_seconds       <= now_seconds;
            item_reg.eapol_packet_type <= eapol_packet_type;
            item_reg.eap_code          <= eap_code;
            item_reg.eap_ident         <= eap_ident;
            item_reg.eap_method        <= eap_method;
        end
        if (move)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign send_frame     = result_reg.send_frame;
    assign session_status = result_reg.session_status;
    assign running        = result_reg.running;
    assign retry_delay    = result_reg.retry_delay;
    assign retry_armed    = result_reg.retry_armed;
    assign retry_at       = result_reg.retry_at;

`include "assert_macros.svh"

    `EAPSC_ASSERT_IMPL(a_armed_delay, clk, rst_n, out_vld_reg, retry_armed == (retry_delay != 11'd0))
    `EAPSC_ASSERT_IMPL(a_armed_stopped, clk, rst_n, out_vld_reg && retry_armed, !running)
    `EAPSC_ASSERT_IMPL(a_start_runs, clk, rst_n, out_vld_reg && send_frame == eapsc_pkg::SEND_START, running && session_status == eapsc_pkg::STAT_STARTED)
    `EAPSC_ASSERT_IMPL(a_at_idle, clk, rst_n, out_vld_reg && !retry_armed, retry_at == 32'd0)

endmodule

`default_nettype wire
